@@ src/vsc_pkg.sv @@
// vsc_pkg: shared types, ascii codes and fixed-point constants for the
// ventilation sensor controller; no dependencies
`default_nettype none

package vsc_pkg;

  // ascii codes on both links
  localparam logic [7:0] CH_S    = 8'h73;  // 's' start of frame
  localparam logic [7:0] CH_E    = 8'h65;  // 'e' end of frame
  localparam logic [7:0] CH_C    = 8'h43;  // 'C' report id
  localparam logic [7:0] CH_A    = 8'h41;  // 'A' window command id
  localparam logic [7:0] CH_AUTO = 8'h45;  // 'E' auto mode frame id
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_2    = 8'h32;

  // window command codes
  localparam logic [7:0] CMD_OPEN  = CH_1;
  localparam logic [7:0] CMD_CLOSE = CH_2;

  // operation codes on the slave side
  localparam logic OP_APP_BYTE = 1'b0;
  localparam logic OP_SENSOR   = 1'b1;

  // link codes on the master side
  localparam logic LINK_APP    = 1'b0;
  localparam logic LINK_WINDOW = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_HUM_LIMIT  = 3'd0;
  localparam logic [2:0] REG_HOT_LIMIT  = 3'd1;
  localparam logic [2:0] REG_COLD_LIMIT = 3'd2;
  localparam logic [2:0] REG_DUST_LOW   = 3'd3;
  localparam logic [2:0] REG_DUST_HIGH  = 3'd4;

  // configuration reset values
  localparam logic [7:0] HUM_LIMIT_RST  = 8'd68;
  localparam logic [7:0] HOT_LIMIT_RST  = 8'd30;
  localparam logic [7:0] COLD_LIMIT_RST = 8'd16;
  localparam logic [9:0] DUST_LOW_RST   = 10'd5;
  localparam logic [9:0] DUST_HIGH_RST  = 10'd600;

  // dust classes
  localparam logic [1:0] DUST_CLEAN = 2'd0;
  localparam logic [1:0] DUST_MID   = 2'd1;
  localparam logic [1:0] DUST_DIRTY = 2'd2;

  // humidity: (raw - 1700) / 120, the divide done as multiply by 2^21/120
  localparam logic [13:0] HUM_OFFSET = 14'd1700;
  localparam logic [14:0] HUM_RECIP  = 15'd17477;
  localparam int          HUM_SHIFT  = 21;

  // temperature: (raw * 165 - 40 * 16384) / 16384
  localparam logic [7:0]  TEMP_SCALE  = 8'd165;
  localparam logic [21:0] TEMP_OFFSET = 22'd655360;
  localparam int          TEMP_SHIFT  = 14;

  // run lengths on the master side
  localparam int REPORT_LEN = 15;
  localparam int CMD_LEN    = 5;
  localparam int RUN_MAX    = REPORT_LEN + CMD_LEN;
  localparam int IDX_W      = $clog2(RUN_MAX);

  // parser phases
  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_DATA     = 4'b0010,
    PH_WAIT_END = 4'b0100,
    PH_PENDING  = 4'b1000
  } phase_e;

  // parser view handed to the decision logic
  typedef struct packed {
    logic       pending;
    logic [7:0] frame_id;
    logic [7:0] first_data;
    logic       auto_en;
  } par_stat_t;

  // classified sensor sample
  typedef struct packed {
    logic [1:0] dust_cls;
    logic       gas;
    logic [7:0] hum;
    logic [7:0] temp;
    logic       hum_high;
    logic       hot;
    logic       cold;
  } sense_t;

  // one sensor step's run, held until the last word leaves
  typedef struct packed {
    logic [1:0] dust_cls;
    logic       gas;
    logic [7:0] hum;
    logic [7:0] temp;
    logic       cmd_en;
    logic [7:0] cmd_code;
  } rec_t;

  // decimal digits of an 8-bit value as {hundreds, tens, ones}
  function automatic logic [11:0] to_digits(logic [7:0] v);
    logic [3:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 4'd0;
      r = v[6:0];
    end
    // r below 100: r*205 >> 11 is r / 10
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = 7'(r - 7'(t) * 7'd10);
    return {h, t, o[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ src/vsc_parser.sv @@
// vsc_parser: app frame parser and auto mode flag
// depends on vsc_pkg
`default_nettype none

module vsc_parser import vsc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_en_i,   // app byte taken
  input  wire logic [7:0] byte_i,
  input  wire logic       step_en_i,   // sensor step taken
  output par_stat_t       stat_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] hdr_cnt_q, hdr_cnt_d;
  logic [7:0] data_cnt_q, data_cnt_d;
  logic [7:0] frame_id_q, frame_id_d;
  logic [7:0] frame_len_q, frame_len_d;
  logic [7:0] first_q, first_d;
  logic       auto_q, auto_d;
  logic [7:0] len_val;
  logic [7:0] cnt_inc;

  assign len_val = byte_i - CH_0;
  assign cnt_inc = data_cnt_q + 8'd1;

  // next state of the frame parser
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    data_cnt_d  = data_cnt_q;
    frame_id_d  = frame_id_q;
    frame_len_d = frame_len_q;
    first_d     = first_q;
    auto_d      = auto_q;
    if (step_en_i) begin
      if (phase_q == PH_PENDING) begin
        if (frame_id_q == CH_AUTO) begin
          if (first_q == CH_1) begin
            auto_d = 1'b1;
          end else if (first_q == CH_0) begin
            auto_d = 1'b0;
          end
        end
        phase_d    = PH_HEADER;
        hdr_cnt_d  = 2'd0;
        data_cnt_d = 8'd0;
      end
    end else if (byte_en_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_cnt_q == 2'd0) begin
            hdr_cnt_d = (byte_i == CH_S) ? 2'd1 : 2'd0;
          end else if (hdr_cnt_q == 2'd1) begin
            frame_id_d = byte_i;
            hdr_cnt_d  = 2'd2;
          end else begin
            frame_len_d = len_val;
            hdr_cnt_d   = 2'd0;
            data_cnt_d  = 8'd0;
            // zero length skips the data bytes
            phase_d     = (len_val == 8'd0) ? PH_WAIT_END : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_cnt_q == 8'd0) begin
            first_d = byte_i;
          end
          if (cnt_inc == frame_len_q) begin
            data_cnt_d = 8'd0;
            phase_d    = PH_WAIT_END;
          end else begin
            data_cnt_d = cnt_inc;
          end
        end
        PH_WAIT_END: begin
          if (byte_i == CH_E) begin
            phase_d = PH_PENDING;
          end
        end
        PH_PENDING: begin
          // app bytes ignored until the next sensor step
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= 2'd0;
      data_cnt_q  <= 8'd0;
      frame_id_q  <= 8'd0;
      frame_len_q <= 8'd0;
      first_q     <= 8'd0;
      auto_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      data_cnt_q  <= data_cnt_d;
      frame_id_q  <= frame_id_d;
      frame_len_q <= frame_len_d;
      first_q     <= first_d;
      auto_q      <= auto_d;
    end
  end

  assign stat_o.pending    = (phase_q == PH_PENDING);
  assign stat_o.frame_id   = frame_id_q;
  assign stat_o.first_data = first_q;
  assign stat_o.auto_en    = auto_q;

endmodule

`default_nettype wire

@@ src/vsc_sense.sv @@
// vsc_sense: fixed-point conversion and classification of one sensor sample
// depends on vsc_pkg
`default_nettype none

module vsc_sense import vsc_pkg::*; (
  input  wire logic [9:0] dust_i,
  input  wire logic       gas_i,
  input  wire logic [7:0] hum_hi_i,
  input  wire logic [7:0] hum_lo_i,
  input  wire logic [7:0] temp_hi_i,
  input  wire logic [7:0] temp_lo_i,
  input  wire logic [7:0] hum_limit_i,
  input  wire logic [7:0] hot_limit_i,
  input  wire logic [7:0] cold_limit_i,
  input  wire logic [9:0] dust_low_i,
  input  wire logic [9:0] dust_high_i,
  output sense_t          sense_o
);

  logic [13:0] h_raw;
  logic        h_neg;
  logic [13:0] h_mag;
  logic [28:0] h_prod;
  logic [7:0]  h_quo;
  logic [7:0]  hum;
  logic [13:0] t_raw;
  logic [21:0] t_prod;
  logic        t_neg;
  logic [21:0] t_mag;
  logic [7:0]  t_quo;
  logic [7:0]  temp;

  // humidity: divide the magnitude by 120, then restore the sign mod 256
  assign h_raw  = {hum_hi_i[5:0], hum_lo_i};
  assign h_neg  = (h_raw < HUM_OFFSET);
  assign h_mag  = h_neg ? (HUM_OFFSET - h_raw) : (h_raw - HUM_OFFSET);
  assign h_prod = 29'(h_mag) * 29'(HUM_RECIP);
  assign h_quo  = h_prod[HUM_SHIFT +: 8];
  assign hum    = h_neg ? (8'd0 - h_quo) : h_quo;

  // temperature: scale, take off the offset, truncate towards zero
  assign t_raw  = {temp_hi_i, 2'b00, temp_lo_i[7:4]};
  assign t_prod = 22'(t_raw) * 22'(TEMP_SCALE);
  assign t_neg  = (t_prod < TEMP_OFFSET);
  assign t_mag  = t_neg ? (TEMP_OFFSET - t_prod) : (t_prod - TEMP_OFFSET);
  assign t_quo  = t_mag[TEMP_SHIFT +: 8];
  assign temp   = t_neg ? (8'd0 - t_quo) : t_quo;

  // classification against the limits
  always_comb begin
    if (dust_i > dust_high_i) begin
      sense_o.dust_cls = DUST_DIRTY;
    end else if (dust_i < dust_low_i) begin
      sense_o.dust_cls = DUST_CLEAN;
    end else begin
      sense_o.dust_cls = DUST_MID;
    end
    sense_o.gas      = gas_i;
    sense_o.hum      = hum;
    sense_o.temp     = temp;
    sense_o.hum_high = (hum >= hum_limit_i);
    sense_o.cold     = (temp < cold_limit_i);
    sense_o.hot      = !(temp < cold_limit_i) && (temp >= hot_limit_i);
  end

endmodule

`default_nettype wire

@@ src/vsc_emitter.sv @@
// vsc_emitter: result register and byte serialiser for report and command runs
// depends on vsc_pkg
`default_nettype none

module vsc_emitter import vsc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire rec_t       rec_i,
  output logic            ready_o,
  output logic            tvalid_o,
  input  wire logic       tready_i,
  output logic [7:0]      tdata_o,
  output logic            tuser_o,
  output logic            tlast_o
);

  rec_t             rec_q;
  logic             valid_q;
  logic [IDX_W-1:0] idx_q;
  logic [11:0]      hum_dig;
  logic [11:0]      temp_dig;
  logic             word_done;
  logic             run_done;

  assign hum_dig  = to_digits(rec_q.hum);
  assign temp_dig = to_digits(rec_q.temp);

  // last word of the run: end of report with no command, or end of command
  assign tlast_o   = ((idx_q == IDX_W'(REPORT_LEN - 1)) && !rec_q.cmd_en) ||
                     (idx_q == IDX_W'(RUN_MAX - 1));
  assign tuser_o   = (idx_q >= IDX_W'(REPORT_LEN)) ? LINK_WINDOW : LINK_APP;
  assign tvalid_o  = valid_q;
  assign word_done = valid_q && tready_i;
  assign run_done  = word_done && tlast_o;
  assign ready_o   = !valid_q || run_done;

  // byte for the current position of the run
  always_comb begin
    case (idx_q)
      IDX_W'(0):  tdata_o = CH_S;
      IDX_W'(1):  tdata_o = CH_C;
      IDX_W'(2):  tdata_o = CH_1;
      IDX_W'(3):  tdata_o = CH_0;
      IDX_W'(4):  tdata_o = CH_0 + 8'(rec_q.dust_cls);
      IDX_W'(5):  tdata_o = CH_0 + 8'(rec_q.gas);
      IDX_W'(6):  tdata_o = CH_0;
      IDX_W'(7):  tdata_o = CH_0 + 8'(hum_dig[11:8]);
      IDX_W'(8):  tdata_o = CH_0 + 8'(hum_dig[7:4]);
      IDX_W'(9):  tdata_o = CH_0 + 8'(hum_dig[3:0]);
      IDX_W'(10): tdata_o = CH_0;
      IDX_W'(11): tdata_o = CH_0 + 8'(temp_dig[11:8]);
      IDX_W'(12): tdata_o = CH_0 + 8'(temp_dig[7:4]);
      IDX_W'(13): tdata_o = CH_0 + 8'(temp_dig[3:0]);
      IDX_W'(14): tdata_o = CH_E;
      IDX_W'(15): tdata_o = CH_S;
      IDX_W'(16): tdata_o = CH_A;
      IDX_W'(17): tdata_o = CH_1;
      IDX_W'(18): tdata_o = rec_q.cmd_code;
      IDX_W'(19): tdata_o = CH_E;
      default:    tdata_o = CH_E;
    endcase
  end

  // run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load_i && ready_o) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else if (run_done) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else if (word_done) begin
        idx_q   <= idx_q + IDX_W'(1);
      end
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      rec_q <= rec_i;
    end
  end

endmodule

`default_nettype wire

@@ src/ventilation_sensor_controller.sv @@
// order: an app byte passes the input register, then updates the parser; a sensor step
// passes the input register and, once the emitter is free, its result register
// throughput: one app byte per cycle while no sensor step waits; one sensor step per run
// of the single byte serialiser (one word per cycle unless stalled, 15 report + 5 command)
// reset: asynchronous active low; parser idle, manual mode, limits to defaults
`default_nettype none

module ventilation_sensor_controller import vsc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rx_byte[7:0], dust_count[17:8], gas_present[18], hum_byte_hi[26:19],
  // hum_byte_lo[34:27], temp_byte_hi[42:35], temp_byte_lo[50:43], zero pad
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,   // operation[0]
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
  output logic             m_axis_tuser,   // link[0]
  output logic             m_axis_tlast,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i
);

  logic        in_valid_q;
  logic        op_q;
  logic [50:0] data_q;
  logic        consume;
  logic        emit_ready;
  logic        emit_load;
  logic        byte_en;
  logic        step_en;
  logic [7:0]  hum_limit_q;
  logic [7:0]  hot_limit_q;
  logic [7:0]  cold_limit_q;
  logic [9:0]  dust_low_q;
  logic [9:0]  dust_high_q;
  par_stat_t   stat;
  sense_t      sense;
  rec_t        rec;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hum_limit_q  <= HUM_LIMIT_RST;
      hot_limit_q  <= HOT_LIMIT_RST;
      cold_limit_q <= COLD_LIMIT_RST;
      dust_low_q   <= DUST_LOW_RST;
      dust_high_q  <= DUST_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HUM_LIMIT:  hum_limit_q  <= cfg_data_i[7:0];
        REG_HOT_LIMIT:  hot_limit_q  <= cfg_data_i[7:0];
        REG_COLD_LIMIT: cold_limit_q <= cfg_data_i[7:0];
        REG_DUST_LOW:   dust_low_q   <= cfg_data_i;
        REG_DUST_HIGH:  dust_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register: app bytes drain at once, sensor steps wait for the emitter
  assign consume       = in_valid_q && ((op_q == OP_APP_BYTE) || emit_ready);
  assign s_axis_tready = !in_valid_q || consume;
  assign byte_en       = in_valid_q && (op_q == OP_APP_BYTE);
  assign step_en       = in_valid_q && (op_q == OP_SENSOR) && emit_ready;
  assign emit_load     = step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q   <= s_axis_tuser;
      data_q <= s_axis_tdata[50:0];
    end
  end

  vsc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .byte_i    (data_q[7:0]),
    .step_en_i (step_en),
    .stat_o    (stat)
  );

  vsc_sense u_sense (
    .dust_i       (data_q[17:8]),
    .gas_i        (data_q[18]),
    .hum_hi_i     (data_q[26:19]),
    .hum_lo_i     (data_q[34:27]),
    .temp_hi_i    (data_q[42:35]),
    .temp_lo_i    (data_q[50:43]),
    .hum_limit_i  (hum_limit_q),
    .hot_limit_i  (hot_limit_q),
    .cold_limit_i (cold_limit_q),
    .dust_low_i   (dust_low_q),
    .dust_high_i  (dust_high_q),
    .sense_o      (sense)
  );

  // window command: pending frame first, else the auto decision
  always_comb begin
    rec.dust_cls = sense.dust_cls;
    rec.gas      = sense.gas;
    rec.hum      = sense.hum;
    rec.temp     = sense.temp;
    rec.cmd_en   = 1'b0;
    rec.cmd_code = CMD_CLOSE;
    if (stat.pending) begin
      rec.cmd_en   = (stat.frame_id == CH_A) && !stat.auto_en;
      rec.cmd_code = stat.first_data;
    end else if (stat.auto_en) begin
      if (sense.gas || sense.hum_high) begin
        rec.cmd_en   = 1'b1;
        rec.cmd_code = CMD_CLOSE;
      end else if (sense.hot) begin
        rec.cmd_en   = 1'b1;
        rec.cmd_code = CMD_OPEN;
      end else if (sense.cold) begin
        rec.cmd_en   = 1'b1;
        rec.cmd_code = CMD_CLOSE;
      end else if (sense.dust_cls == DUST_DIRTY) begin
        rec.cmd_en   = 1'b1;
        rec.cmd_code = CMD_OPEN;
      end
    end
  end

  vsc_emitter u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit_load),
    .rec_i    (rec),
    .ready_o  (emit_ready),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ src/vsc_checker.sv @@
// vsc_checker: port-level assertions on the master side of the controller,
// bound to the top level; depends on vsc_pkg
`default_nettype none

module vsc_checker import vsc_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // stalled word holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("master word changed while stalled");

  // every run closes with the end-of-frame byte
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_E)
    else $error("run closed without end byte");

  // words of a run follow one another without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run");

  // once on the window link, a run stays there to its end
  a_link_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tuser == LINK_WINDOW
      |=> m_axis_tuser == LINK_WINDOW)
    else $error("window command run switched link");

endmodule

bind ventilation_sensor_controller vsc_checker u_vsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
